>>> sv/mis_pkg.sv
package mis_pkg;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W = 31;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_result;
    logic               overflow;
  } out_item_t;
endpackage

>>> sv/mis_ram.sv
module mis_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/mis_ctrl.sv
module mis_ctrl #(
  parameter int MAX_ITEMS = mis_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_last,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_last,
  output logic                         ovf,
  input  logic                         le,
  output logic [$clog2(MAX_ITEMS)-1:0] waddr,
  output logic [$clog2(MAX_ITEMS)-1:0] raddr,
  output logic                         we,
  output logic                         wsel_key,
  output logic                         key_load,
  output logic                         show_load
);
  import mis_pkg::*;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    LOAD, I_START, K_RD, K_WAIT, B_RD, B_WAIT, B_CMP, S_RD, S_WAIT, S_WR, OUT_RD,
    OUT_WAIT, OUT_SHOW
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] i, lo, hi, k, pos;
  logic          ovf_seen;
  logic [CW-1:0] mid;

  assign mid       = lo + ((hi - lo) >> 1);
  assign in_ready  = (state == LOAD);
  assign key_load  = (state == K_WAIT);
  assign show_load = (state == OUT_WAIT);

  always_comb begin
    we = 1'b0;
    wsel_key = 1'b0;
    waddr = '0;
    raddr = '0;
    case (state)
      LOAD: begin
        we = in_valid && (count < CW'(MAX_ITEMS));
        waddr = count[AW-1:0];
      end
      K_RD: raddr = i[AW-1:0];
      B_RD, B_WAIT: raddr = mid[AW-1:0];
      S_RD, S_WAIT: raddr = k[AW-1:0] - AW'(1);
      S_WR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wsel_key = (k == lo);
      end
      OUT_RD: raddr = pos[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      ovf_seen <= 1'b0;
      out_valid <= 1'b0;
      out_last <= 1'b0;
      ovf <= 1'b0;
      i <= '0; lo <= '0; hi <= '0; k <= '0; pos <= '0;
    end else begin
      case (state)
        LOAD: if (in_valid) begin
          if (count < CW'(MAX_ITEMS)) begin
            count <= count + CW'(1);
          end else begin
            ovf_seen <= 1'b1;
          end
          if (in_last) begin
            state <= I_START;
            i <= CW'(1);
          end
        end
        I_START: begin
          if (i >= count) begin
            pos <= '0;
            state <= OUT_RD;
          end else begin
            state <= K_RD;
          end
        end
        K_RD: state <= K_WAIT;
        K_WAIT: begin
          lo <= '0;
          hi <= i;
          state <= B_RD;
        end
        B_RD: state <= (lo < hi) ? B_WAIT : S_RD;
        B_WAIT: state <= B_CMP;
        B_CMP: begin
          if (le) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= B_RD;
        end
        S_RD: begin
          if (lo == hi && k != lo) begin
            state <= S_WAIT;
          end else begin
            state <= S_WR;
          end
        end
        S_WAIT: state <= S_WR;
        S_WR: begin
          if (k == lo) begin
            i <= i + CW'(1);
            state <= I_START;
          end else begin
            k <= k - CW'(1);
            state <= S_RD;
          end
        end
        OUT_RD: state <= OUT_WAIT;
        OUT_WAIT: begin
          out_valid <= 1'b1;
          out_last <= (pos + CW'(1) == count);
          ovf <= ovf_seen;
          state <= OUT_SHOW;
        end
        OUT_SHOW: if (out_ready) begin
          out_valid <= 1'b0;
          if (out_last) begin
            count <= '0;
            ovf_seen <= 1'b0;
            state <= LOAD;
          end else begin
            pos <= pos + CW'(1);
            state <= OUT_RD;
          end
        end
        default: state <= LOAD;
      endcase
      if (state == K_WAIT) begin
        k <= i;
      end
    end
  end
endmodule

>>> sv/mis_dp.sv
module mis_dp #(
  parameter int MAX_ITEMS = mis_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic [mis_pkg::VALUE_W-1:0]  in_value,
  input  logic                         we,
  input  logic                         wsel_key,
  input  logic                         key_load,
  input  logic [$clog2(MAX_ITEMS)-1:0] waddr,
  input  logic [$clog2(MAX_ITEMS)-1:0] raddr,
  input  logic                         loading,
  output logic                         le,
  output logic [mis_pkg::VALUE_W-1:0]  rdata
);
  import mis_pkg::*;
  logic [VALUE_W-1:0] key, wdata;

  assign wdata = loading ? in_value : (wsel_key ? key : rdata);
  assign le    = (rdata <= key);

  always_ff @(posedge clk) begin
    if (key_load) begin
      key <= rdata;
    end
  end

  mis_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
endmodule

>>> sv/merge_insertion_sorter_unit.sv
// Sorting runs after the last item, inserting each stored item in turn by binary search;
// binary insertion through one single-port-read memory sets the pace.
// Loading accepts one item per cycle; each result is read from the store, registered, then held until taken.
// Throughput: one batch at a time; input stalls from last item until final result taken.
// Reset (rst, synchronous) empties the batch; the store contents stay undefined.
module merge_insertion_sorter_unit #(
  parameter int MAX_ITEMS = mis_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mis_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mis_pkg::out_item_t out_item
);
  import mis_pkg::*;
  localparam int AW = $clog2(MAX_ITEMS);

  logic          le, we, wsel_key, out_last, ovf;
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_W-1:0] rdata, shown;
  logic          key_load, show_load;

  mis_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_item.last_item),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .out_last(out_last), .ovf(ovf), .le(le), .waddr(waddr), .raddr(raddr),
    .we(we), .wsel_key(wsel_key), .key_load(key_load), .show_load(show_load)
  );

  mis_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk(clk), .in_value(in_item.value), .we(we), .wsel_key(wsel_key),
    .key_load(key_load), .waddr(waddr), .raddr(raddr), .loading(in_ready),
    .le(le), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (show_load) begin
      shown <= rdata;
    end
  end

  assign out_item.sorted_value = shown;
  assign out_item.last_result  = out_last;
  assign out_item.overflow     = ovf;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input open during output");
  a_last_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_item.last_result) |=> !out_valid)
    else $error("valid after last result");
endmodule

>>> verif/tb_merge_insertion_sorter_unit.sv
`timescale 1ns / 100ps

module tb_merge_insertion_sorter_unit;
  import mis_pkg::*;

  localparam int CAP = MAX_ITEMS_DEF;
  localparam int ROWS = 12;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last_item;
    logic               typed;
    logic [VALUE_W-1:0] want_value;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;

  merge_insertion_sorter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  logic [VALUE_W-1:0] batch_vals[$];
  logic               batch_dropped;
  out_item_t          sorted_expect[$];
  int                 mismatches;
  int                 row_errs;
  stim_row_t          rows[ROWS];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic take_item(input logic [VALUE_W-1:0] v, input logic last);
    out_item_t r;
    logic [VALUE_W-1:0] vals[$];
    if (batch_vals.size() < CAP) batch_vals = {batch_vals, v};
    else batch_dropped = 1'b1;
    if (last) begin
      vals = batch_vals;
      vals.sort();
      foreach (vals[k]) begin
        r.sorted_value = vals[k];
        r.last_result  = (k == vals.size() - 1);
        r.overflow     = batch_dropped;
        sorted_expect = {sorted_expect, r};
      end
      batch_vals.delete();
      batch_dropped = 1'b0;
    end
  endtask

  task automatic send(input logic [VALUE_W-1:0] v, input logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{value: v, last_item: last};
    do @(posedge clk); while (!in_ready);
    take_item(v, last);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (sorted_expect.size() != 0);
  endtask

  task automatic send_batch(input int n, input int mode);
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = VALUE_W'($urandom);
        1: v = VALUE_W'($urandom_range(0, 7));
        2: v = VALUE_W'(i);
        default: v = VALUE_W'(n - i);
      endcase
      send(v, i == n - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (sorted_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        if (out_item !== sorted_expect[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", sorted_expect[0], out_item);
        end
        void'(sorted_expect.pop_front());
      end
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= (stall == 0);
      end else if (out_valid && out_ready) begin
        stall = $urandom_range(0, 4);
        out_ready <= (stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int sent;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    mismatches = 0;
    row_errs = 0;
    batch_dropped = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{31'h7fffffff, 1'b1, 1'b1, 31'h7fffffff},
      '{31'd1, 1'b1, 1'b1, 31'd1},
      '{31'd0, 1'b1, 1'b1, 31'd0},
      '{31'h7fffffff, 1'b0, 1'b0, 31'd0},
      '{31'd1, 1'b0, 1'b0, 31'd0},
      '{31'd0, 1'b0, 1'b0, 31'd0},
      '{31'h55555555, 1'b0, 1'b0, 31'd0},
      '{31'h2aaaaaaa, 1'b0, 1'b0, 31'd0},
      '{31'd1, 1'b1, 1'b0, 31'd0},
      '{31'd5, 1'b0, 1'b0, 31'd0},
      '{31'd5, 1'b0, 1'b0, 31'd0},
      '{31'd5, 1'b1, 1'b0, 31'd0}
    };
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        drain();
        send(rows[i].value, rows[i].last_item);
        if (sorted_expect.size() != 1 || sorted_expect[0].sorted_value !== rows[i].want_value
            || sorted_expect[0].overflow !== 1'b0) begin
          row_errs++;
          $display("row %0d: expected single result %h", i, rows[i].want_value);
        end
      end else begin
        send(rows[i].value, rows[i].last_item);
      end
    end
    drain();

    send_batch(CAP, 3);
    send_batch(CAP + 1, 0);
    drain();
    for (int i = 0; i < CAP; i++) send(31'd9, 1'b0);
    send(31'h7fffffff, 1'b1);
    drain();
    sent = ROWS + 3 * CAP + 2;

    while (sent < 470) begin
      int n;
      int pick;
      pick = $urandom_range(0, 19);
      n = (pick == 0) ? $urandom_range(CAP - 2, CAP + 3) : $urandom_range(1, 12);
      send_batch(n, $urandom_range(0, 3));
      sent += n;
      if ($urandom_range(0, 5) == 0) drain();
    end
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && row_errs == 0 && sorted_expect.size() == 0
        && batch_vals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/mis_pkg.sv
sv/mis_ram.sv
sv/mis_ctrl.sv
sv/mis_dp.sv
sv/merge_insertion_sorter_unit.sv
verif/tb_merge_insertion_sorter_unit.sv
